@@ rtl/tsrpf_pkg.sv @@
// Package for the two-step ratio-pair forager: payload structs, opcodes, sizes.
// No dependencies.
package tsrpf_pkg;

   localparam int MaxTargets = 1024;
   localparam int IdxW       = $clog2(MaxTargets);
   localparam int CntW       = IdxW + 1;
   localparam int MaxSize    = 1000;
   localparam logic [19:0] TotalMax = 20'hFFFFF;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_STEP  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   localparam logic CSR_START_X = 1'b0;
   localparam logic CSR_START_Y = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] target_x;
      logic [15:0] target_y;
      logic [9:0]  target_size;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [9:0]  visit_index;
      logic [15:0] visit_x;
      logic [15:0] visit_y;
      logic [16:0] leg_length;
      logic [9:0]  visit_size;
      logic [19:0] total_collected;
      logic        last;
   } rsp_type;

endpackage

@@ rtl/tsrpf_dist.sv @@
// Iterative distance unit: floor sqrt of dx^2+dy^2, one root bit per cycle.
// Depends on tsrpf_pkg.
module tsrpf_dist
   import tsrpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] ax,
   input  logic [15:0] ay,
   input  logic [15:0] bx,
   input  logic [15:0] by,
   output logic        done,
   output logic [16:0] root
);
   typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT} state_type;
   state_type   state_ff;
   logic [15:0] dx_ff, dy_ff;
   logic [32:0] rem_ff;
   logic [16:0] root_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] sq;
   logic        phase_ff;
   logic [34:0] trial;
   logic [34:0] remsh;
   logic [33:0] val_ff;

   assign sq = phase_ff ? 32'(dy_ff) * 32'(dy_ff) : 32'(dx_ff) * 32'(dx_ff);
   assign remsh = {rem_ff[32:0], val_ff[33:32]};
   assign trial = {16'b0, root_ff, 2'b01};
   assign root = root_ff;

   always_ff @(posedge clock) begin
      done <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  dx_ff <= (ax > bx) ? ax - bx : bx - ax;
                  dy_ff <= (ay > by) ? ay - by : by - ay;
                  phase_ff <= 1'b0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (!phase_ff) begin
                  val_ff <= 34'(sq);
                  phase_ff <= 1'b1;
               end else begin
                  val_ff <= val_ff + 34'(sq);
                  rem_ff <= '0;
                  root_ff <= '0;
                  cnt_ff <= 5'd17;
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (remsh >= trial) begin
                  rem_ff <= 33'(remsh - trial);
                  root_ff <= {root_ff[15:0], 1'b1};
               end else begin
                  rem_ff <= remsh[32:0];
                  root_ff <= {root_ff[15:0], 1'b0};
               end
               val_ff <= {val_ff[31:0], 2'b00};
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd1) begin
                  done <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ rtl/two_step_ratio_pair_forager_top.sv @@
// Top level of the two-step ratio-pair forager: target table, pair scan sequencer.
// Depends on tsrpf_pkg and tsrpf_dist.
//
// Usage: req_ carries load, step and clear items (valid/stall). Load and clear
// pass through a wait state and give no result. A step scans all ordered pairs
// of loaded targets; each pair of unvisited targets is measured in the shared
// distance unit (one 16x16 multiplier, one root bit per cycle), after the leg
// from the walker to each unvisited first target. It then gives two results on
// rsp_ (or one no-pair result) with last on the final one. While busy or while
// rsp_stall holds a result, req_stall stays high.
// csr_ writes start_x (index 0) and start_y (index 1); always ready.
// Reset (synchronous) empties the table, zeroes the total and puts the walker
// at the start point. The table itself is not cleared.
module two_step_ratio_pair_forager_top
   import tsrpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_RDI, S_DI0, S_DI1, S_RDW, S_DW0, S_DW1, S_CMP, S_NEXT,
      S_OUT1, S_OUT2, S_NOPAIR, S_WAIT
   } state_type;

   logic [15:0] mem_x [MaxTargets];
   logic [15:0] mem_y [MaxTargets];
   logic [9:0]  mem_s [MaxTargets];
   logic [15:0] rd_x_ff, rd_y_ff;
   logic [9:0]  rd_s_ff;
   logic [IdxW-1:0] rd_addr;
   logic        wr_en;
   logic [IdxW-1:0] wr_addr;
   logic [15:0] wr_x, wr_y;
   logic [9:0]  wr_s;
   logic        wr_xy;

   state_type   state_ff;
   logic [CntW-1:0] count_ff;
   logic [15:0] start_x_ff, start_y_ff, walk_x_ff, walk_y_ff;
   logic [19:0] total_ff;
   logic [CntW-1:0] i_ff, w_ff;
   logic [15:0] ix_ff, iy_ff, wx_ff, wy_ff;
   logic [9:0]  is_ff;
   logic [16:0] l1_ff, l2_ff;
   logic        found_ff;
   logic [IdxW-1:0] bi_ff, bw_ff;
   logic [17:0] bnum_ff;
   logic [10:0] bden_ff;
   logic [16:0] bl1_ff, bl2_ff;
   logic [15:0] bix_ff, biy_ff, bwx_ff, bwy_ff;
   logic [9:0]  bis_ff, bws_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [9:0]  ld_size;

   logic        d_start, d_done;
   logic [15:0] d_ax, d_ay, d_bx, d_by;
   logic [16:0] d_root;
   logic [17:0] num;
   logic [10:0] den;
   logic [28:0] lhs, rhs;
   logic [20:0] tsum1, tsum2;
   logic [19:0] tot1, tot2;

   tsrpf_dist u_dist (
      .clock(clock), .reset(reset), .start(d_start),
      .ax(d_ax), .ay(d_ay), .bx(d_bx), .by(d_by), .done(d_done), .root(d_root)
   );

   assign ld_size = (req_data.target_size > 10'(MaxSize)) ? 10'(MaxSize)
                                                         : req_data.target_size;
   assign num = 18'(l1_ff) + 18'(d_root);
   assign den = 11'(is_ff) + 11'(rd_s_ff);
   assign lhs = 29'(num) * 29'(bden_ff);
   assign rhs = 29'(bnum_ff) * 29'(den);
   assign tsum1 = 21'(total_ff) + 21'(bis_ff);
   assign tot1 = tsum1[20] ? TotalMax : tsum1[19:0];
   assign tsum2 = 21'(tot1) + 21'(bws_ff);
   assign tot2 = tsum2[20] ? TotalMax : tsum2[19:0];

   assign d_start = ((state_ff == S_DI0) || (state_ff == S_DW0)) && (rd_s_ff != '0);
   assign d_ax = (state_ff == S_DI0) ? walk_x_ff : ix_ff;
   assign d_ay = (state_ff == S_DI0) ? walk_y_ff : iy_ff;
   assign d_bx = (state_ff == S_DI0) ? rd_x_ff : rd_x_ff;
   assign d_by = rd_y_ff;

   always_comb begin
      rd_addr = (state_ff == S_RDW || state_ff == S_DW0 || state_ff == S_DW1 ||
                 state_ff == S_CMP) ? w_ff[IdxW-1:0] : i_ff[IdxW-1:0];
      wr_en = 1'b0;
      wr_xy = 1'b0;
      wr_addr = count_ff[IdxW-1:0];
      wr_x = req_data.target_x;
      wr_y = req_data.target_y;
      wr_s = ld_size;
      if (state_ff == S_IDLE && req_valid && req_data.opcode == OP_LOAD &&
          count_ff < CntW'(MaxTargets)) begin
         wr_en = 1'b1;
         wr_xy = 1'b1;
      end else if (state_ff == S_OUT1 && !rsp_stall) begin
         wr_en = 1'b1;
         wr_addr = bi_ff;
         wr_s = '0;
      end else if (state_ff == S_OUT2 && rsp_valid_ff && !rsp_stall) begin
         wr_en = 1'b1;
         wr_addr = bw_ff;
         wr_s = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_s[wr_addr] <= wr_s;
         if (wr_xy) begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
         end
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
      rd_s_ff <= mem_s[rd_addr];
   end

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         start_x_ff <= 16'd32768;
         start_y_ff <= 16'd32768;
         walk_x_ff <= 16'd32768;
         walk_y_ff <= 16'd32768;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_START_X) start_x_ff <= csr_data;
            else start_y_ff <= csr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  case (req_data.opcode)
                     OP_LOAD: begin
                        if (count_ff < CntW'(MaxTargets)) count_ff <= count_ff + CntW'(1);
                        state_ff <= S_WAIT;
                     end
                     OP_STEP: begin
                        i_ff <= '0;
                        found_ff <= 1'b0;
                        state_ff <= S_RDI;
                     end
                     OP_CLEAR: begin
                        count_ff <= '0;
                        walk_x_ff <= start_x_ff;
                        walk_y_ff <= start_y_ff;
                        total_ff <= '0;
                        state_ff <= S_WAIT;
                     end
                     default: state_ff <= S_WAIT;
                  endcase
               end
            end
            S_WAIT: state_ff <= S_IDLE;
            S_RDI: begin
               if (i_ff >= count_ff) state_ff <= found_ff ? S_OUT1 : S_NOPAIR;
               else state_ff <= S_DI0;
            end
            S_DI0: begin
               ix_ff <= rd_x_ff;
               iy_ff <= rd_y_ff;
               is_ff <= rd_s_ff;
               if (rd_s_ff == '0) begin
                  i_ff <= i_ff + CntW'(1);
                  state_ff <= S_RDI;
               end else begin
                  state_ff <= S_DI1;
               end
            end
            S_DI1: begin
               if (d_done) begin
                  l1_ff <= d_root;
                  w_ff <= '0;
                  state_ff <= S_RDW;
               end
            end
            S_RDW: begin
               if (w_ff >= count_ff) begin
                  i_ff <= i_ff + CntW'(1);
                  state_ff <= S_RDI;
               end else if (w_ff == i_ff) begin
                  w_ff <= w_ff + CntW'(1);
               end else begin
                  state_ff <= S_DW0;
               end
            end
            S_DW0: begin
               if (rd_s_ff == '0) begin
                  w_ff <= w_ff + CntW'(1);
                  state_ff <= S_RDW;
               end else begin
                  state_ff <= S_DW1;
               end
            end
            S_DW1: if (d_done) state_ff <= S_CMP;
            S_CMP: begin
               if (!found_ff || lhs < rhs) begin
                  found_ff <= 1'b1;
                  bi_ff <= i_ff[IdxW-1:0];
                  bw_ff <= w_ff[IdxW-1:0];
                  bnum_ff <= num;
                  bden_ff <= den;
                  bl1_ff <= l1_ff;
                  bl2_ff <= d_root;
                  bix_ff <= ix_ff;
                  biy_ff <= iy_ff;
                  bis_ff <= is_ff;
                  bwx_ff <= rd_x_ff;
                  bwy_ff <= rd_y_ff;
                  bws_ff <= rd_s_ff;
               end
               w_ff <= w_ff + CntW'(1);
               state_ff <= S_RDW;
            end
            S_NOPAIR: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{1'b1, 10'd0, 16'd0, 16'd0, 17'd0, 10'd0, total_ff, 1'b1};
               end else if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            S_OUT1: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{1'b0, bi_ff, bix_ff, biy_ff, bl1_ff, bis_ff, tot1, 1'b0};
               end else if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_OUT2;
               end
            end
            S_OUT2: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{1'b0, bw_ff, bwx_ff, bwy_ff, bl2_ff, bws_ff, tot2, 1'b1};
               end else if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  total_ff <= rsp_ff.total_collected;
                  walk_x_ff <= bwx_ff;
                  walk_y_ff <= bwy_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accept while busy");
   a_last_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && state_ff == S_OUT1) |-> !rsp_data.last) else $error("last early");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxTargets)) else $error("count overflow");
endmodule
